// ----- rtl/core/tips_pkg.sv -----
// ----------------------------------------------------------------------------
// tips_pkg
// shared types, register codes and constants of the tank phase sequencer
// ----------------------------------------------------------------------------
package tips_pkg;

  // phase codes
  typedef enum logic [1:0] {
    PH_FILL   = 2'd0,
    PH_AERATE = 2'd1,
    PH_SETTLE = 2'd2,
    PH_DRAIN  = 2'd3
  } phase_t;

  // field widths
  localparam int KEY_W       = 3;
  localparam int DIST_W      = 12;
  localparam int TIME_W      = 32;
  localparam int SECS_W      = 16;
  localparam int LIMIT_W     = 26;
  localparam int ELAPSED_W   = 23;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // key codes
  localparam logic [KEY_W-1:0] KEY_RIGHT  = 3'd0;
  localparam logic [KEY_W-1:0] KEY_SELECT = 3'd4;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_AUTO_MODE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_START_PHASE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_FULL  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_EMPTY = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_AERATE_SECS = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_SECS = 3'd5;

  // register reset values
  localparam logic               AUTO_MODE_RST   = 1'b1;
  localparam phase_t             START_PHASE_RST = PH_FILL;
  localparam logic [DIST_W-1:0]  LEVEL_FULL_RST  = 12'd160;
  localparam logic [DIST_W-1:0]  LEVEL_EMPTY_RST = 12'd480;
  localparam int                 MS_PER_SEC      = 1000;
  localparam logic [LIMIT_W-1:0] AERATE_MS_RST   = LIMIT_W'(20 * MS_PER_SEC);
  localparam logic [LIMIT_W-1:0] SETTLE_MS_RST   = LIMIT_W'(20 * MS_PER_SEC);

  // ms to seconds: drop three bits (divide by 8), then multiply by
  // ceil(2^36 / 125); exact for every 29-bit operand
  localparam int               DIV_PRE_SHIFT = 3;
  localparam int               DIV_IN_W      = TIME_W - DIV_PRE_SHIFT;
  localparam int               DIV_RECIP_W   = 30;
  localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 30'd549755814;
  localparam int               DIV_SHIFT     = 36;
  localparam int               DIV_PROD_W    = DIV_IN_W + DIV_RECIP_W;

  typedef struct packed {
    logic               auto_mode;
    phase_t             start_phase;
    logic [DIST_W-1:0]  level_full;
    logic [DIST_W-1:0]  level_empty;
    logic [LIMIT_W-1:0] aerate_ms;
    logic [LIMIT_W-1:0] settle_ms;
  } cfg_t;

  typedef struct packed {
    logic   load;
    phase_t value;
  } restart_t;

  typedef struct packed {
    phase_t phase;
    logic   fill_pump;
    logic   air_pump;
    logic   drain_pump;
    logic   entry_pending;
    logic   forced;
  } status_t;

  // seconds to ms as 1024*s - 16*s - 8*s
  function automatic logic [LIMIT_W-1:0] secs_to_ms(input logic [SECS_W-1:0] s);
    logic [LIMIT_W-1:0] x1024;
    logic [LIMIT_W-1:0] x16;
    logic [LIMIT_W-1:0] x8;
    x1024 = {s, 10'b0};
    x16   = {6'b0, s, 4'b0};
    x8    = {7'b0, s, 3'b0};
    return x1024 - x16 - x8;
  endfunction

endpackage

// ----- rtl/core/tips_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// tips_cfg_regs
// configuration registers; timer limits kept in ms for a direct compare
// ----------------------------------------------------------------------------
module tips_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tips_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tips_pkg::CFG_DATA_W-1:0]  cfg_data,
  output tips_pkg::cfg_t                   cfg,
  output tips_pkg::restart_t               restart
);
  import tips_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.auto_mode   <= AUTO_MODE_RST;
      cfg.start_phase <= START_PHASE_RST;
      cfg.level_full  <= LEVEL_FULL_RST;
      cfg.level_empty <= LEVEL_EMPTY_RST;
      cfg.aerate_ms   <= AERATE_MS_RST;
      cfg.settle_ms   <= SETTLE_MS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_AUTO_MODE:   cfg.auto_mode   <= cfg_data[0];
        REG_START_PHASE: cfg.start_phase <= phase_t'(cfg_data[1:0]);
        REG_LEVEL_FULL:  cfg.level_full  <= cfg_data[DIST_W-1:0];
        REG_LEVEL_EMPTY: cfg.level_empty <= cfg_data[DIST_W-1:0];
        REG_AERATE_SECS: cfg.aerate_ms   <= secs_to_ms(cfg_data[SECS_W-1:0]);
        REG_SETTLE_SECS: cfg.settle_ms   <= secs_to_ms(cfg_data[SECS_W-1:0]);
        default: ;
      endcase
    end
  end

  // a start phase write restarts the sequence at once
  assign restart.load  = cfg_valid && (cfg_index == REG_START_PHASE);
  assign restart.value = phase_t'(cfg_data[1:0]);

endmodule

// ----- rtl/core/tips_phase_ctrl.sv -----
// ----------------------------------------------------------------------------
// tips_phase_ctrl
// phase state and per-tick step: entry, skip, force, thresholds, timers
// ----------------------------------------------------------------------------
module tips_phase_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [tips_pkg::KEY_W-1:0]  button,
  input  logic [tips_pkg::KEY_W-1:0]  confirm_button,
  input  logic [tips_pkg::DIST_W-1:0] distance,
  input  logic [tips_pkg::TIME_W-1:0] now_ms,
  input  tips_pkg::cfg_t              cfg,
  input  tips_pkg::restart_t          restart,
  output tips_pkg::status_t           status_next,
  output logic [tips_pkg::TIME_W-1:0] elapsed_ms_next
);
  import tips_pkg::*;

  phase_t              phase;
  logic                pending;
  logic                force_flag;
  logic [TIME_W-1:0]   start_ms;
  logic                fill_on;
  logic                air_on;
  logic                drain_on;

  phase_t              phase_next;
  logic                pending_next;
  logic                force_next;
  logic [TIME_W-1:0]   start_ms_next;
  logic                fill_next;
  logic                air_next;
  logic                drain_next;

  logic [TIME_W-1:0]   diff_ms;
  logic                full_hit;
  logic                empty_hit;
  logic                aerate_hit;
  logic                settle_hit;
  logic                sel_confirmed;

  assign diff_ms       = now_ms - start_ms;
  assign full_hit      = (distance != '0) && (distance <= cfg.level_full);
  assign empty_hit     = (distance != '0) && (distance >= cfg.level_empty);
  assign aerate_hit    = diff_ms >= {{(TIME_W-LIMIT_W){1'b0}}, cfg.aerate_ms};
  assign settle_hit    = diff_ms >= {{(TIME_W-LIMIT_W){1'b0}}, cfg.settle_ms};
  assign sel_confirmed = (button == KEY_SELECT) && (confirm_button == KEY_SELECT);

  always_comb begin
    phase_next    = phase;
    pending_next  = pending;
    force_next    = force_flag;
    start_ms_next = start_ms;
    fill_next     = fill_on;
    air_next      = air_on;
    drain_next    = drain_on;
    if (pending) begin
      fill_next     = (phase == PH_FILL);
      air_next      = (phase == PH_AERATE);
      drain_next    = (phase == PH_DRAIN);
      start_ms_next = now_ms;
      force_next    = 1'b0;
      pending_next  = 1'b0;
    end else if (!cfg.auto_mode && (button == KEY_RIGHT)) begin
      phase_next   = phase_t'(phase + 2'd1);
      pending_next = 1'b1;
    end else begin
      if (!cfg.auto_mode && (phase != PH_SETTLE) && sel_confirmed) begin
        force_next = 1'b1;
      end
      unique case (phase)
        PH_FILL: begin
          if (full_hit) begin
            if (cfg.auto_mode) begin
              fill_next    = 1'b0;
              phase_next   = PH_AERATE;
              pending_next = 1'b1;
            end else begin
              fill_next = force_next;
            end
          end
        end
        PH_AERATE: begin
          if (aerate_hit) begin
            if (cfg.auto_mode) begin
              air_next     = 1'b0;
              phase_next   = PH_SETTLE;
              pending_next = 1'b1;
            end else begin
              air_next = force_next;
            end
          end
        end
        PH_SETTLE: begin
          if (cfg.auto_mode && settle_hit) begin
            phase_next   = PH_DRAIN;
            pending_next = 1'b1;
          end
        end
        PH_DRAIN: begin
          if (empty_hit) begin
            if (cfg.auto_mode) begin
              drain_next   = 1'b0;
              phase_next   = PH_FILL;
              pending_next = 1'b1;
            end else begin
              drain_next = force_next;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= START_PHASE_RST;
      pending    <= 1'b1;
      force_flag <= 1'b0;
      start_ms   <= '0;
      fill_on    <= 1'b0;
      air_on     <= 1'b0;
      drain_on   <= 1'b0;
    end else if (restart.load) begin
      phase   <= restart.value;
      pending <= 1'b1;
    end else if (accept) begin
      phase      <= phase_next;
      pending    <= pending_next;
      force_flag <= force_next;
      start_ms   <= start_ms_next;
      fill_on    <= fill_next;
      air_on     <= air_next;
      drain_on   <= drain_next;
    end
  end

  // result of this tick, as seen after the step
  assign status_next.phase         = phase_next;
  assign status_next.fill_pump     = fill_next;
  assign status_next.air_pump      = air_next;
  assign status_next.drain_pump    = drain_next;
  assign status_next.entry_pending = pending_next;
  assign status_next.forced        = force_next;
  assign elapsed_ms_next           = now_ms - start_ms_next;

endmodule

// ----- rtl/core/tips_result_pipe.sv -----
// ----------------------------------------------------------------------------
// tips_result_pipe
// two-stage result pipeline: ms to whole seconds by reciprocal multiply
// ----------------------------------------------------------------------------
module tips_result_pipe (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  tips_pkg::status_t              status_in,
  input  logic [tips_pkg::TIME_W-1:0]    elapsed_ms_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output tips_pkg::status_t              status_out,
  output logic [tips_pkg::ELAPSED_W-1:0] elapsed_secs
);
  import tips_pkg::*;

  logic                  s1_valid;
  status_t               s1_status;
  logic [TIME_W-1:0]     s1_ms;
  logic                  s2_valid;
  status_t               s2_status;
  logic [ELAPSED_W-1:0]  s2_secs;

  logic                  s1_ready;
  logic                  s2_ready;
  logic [DIV_IN_W-1:0]   div_in;
  logic [DIV_PROD_W-1:0] prod;

  assign s2_ready = !s2_valid || !out_stall;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_stall = !s1_ready;

  assign div_in = s1_ms[TIME_W-1:DIV_PRE_SHIFT];
  assign prod   = {{DIV_RECIP_W{1'b0}}, div_in} * {{DIV_IN_W{1'b0}}, DIV_RECIP};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid;
      if (s2_ready) s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_status <= status_in;
      s1_ms     <= elapsed_ms_in;
    end
    if (s2_ready && s1_valid) begin
      s2_status <= s1_status;
      s2_secs   <= prod[DIV_SHIFT+ELAPSED_W-1:DIV_SHIFT];
    end
  end

  assign out_valid    = s2_valid;
  assign status_out   = s2_status;
  assign elapsed_secs = s2_secs;

endmodule

// ----- rtl/core/tank_irrigation_phase_sequencer.sv -----
// ----------------------------------------------------------------------------
// tank_irrigation_phase_sequencer
// four-phase pump sequencer (fill, aerate, settle, drain) driven by ticks
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake             payload
//  -------   ---------  --------------------  ---------------------------------
//  in        request    in_valid / in_stall   button, confirm_button, distance,
//                                             now_ms
//  out       result     out_valid / out_stall phase, fill_pump, air_pump,
//                                             drain_pump, entry_pending,
//                                             elapsed_secs, forced
//  cfg       write      cfg_valid / cfg_ready cfg_index, cfg_data
//
//  one request per cycle sustained while in_stall is low; its result passes
//  the result register, then the ms-to-seconds multiply stage
//  the phase state updates in the cycle a request is accepted, so the next
//  request sees it at once
//  rst is synchronous; it restores the register defaults and the entry step
//  a stalled output holds both pipeline stages; in_stall rises only when
//  both stages are full and out_stall is high
//  cfg_ready is always high
//
module tank_irrigation_phase_sequencer (
  input  logic                             clk,
  input  logic                             rst,
  // tick requests
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tips_pkg::KEY_W-1:0]       button,
  input  logic [tips_pkg::KEY_W-1:0]       confirm_button,
  input  logic [tips_pkg::DIST_W-1:0]      distance,
  input  logic [tips_pkg::TIME_W-1:0]      now_ms,
  // results
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       phase,
  output logic                             fill_pump,
  output logic                             air_pump,
  output logic                             drain_pump,
  output logic                             entry_pending,
  output logic [tips_pkg::ELAPSED_W-1:0]   elapsed_secs,
  output logic                             forced,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tips_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tips_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tips_pkg::*;

  cfg_t              cfg;
  restart_t          restart;
  status_t           status_next;
  status_t           status_out;
  logic [TIME_W-1:0] elapsed_ms_next;
  logic              accept;

  // a tick request is taken when valid and not stalled
  assign accept = in_valid && !in_stall;

  // register file; timer limits are stored premultiplied to ms
  tips_cfg_regs u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg        (cfg),
    .restart    (restart)
  );

  // phase state and the per-tick decision
  tips_phase_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .button          (button),
    .confirm_button  (confirm_button),
    .distance        (distance),
    .now_ms          (now_ms),
    .cfg             (cfg),
    .restart         (restart),
    .status_next     (status_next),
    .elapsed_ms_next (elapsed_ms_next)
  );

  // result register and seconds conversion
  tips_result_pipe u_pipe (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .status_in     (status_next),
    .elapsed_ms_in (elapsed_ms_next),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status_out    (status_out),
    .elapsed_secs  (elapsed_secs)
  );

  assign phase         = status_out.phase;
  assign fill_pump     = status_out.fill_pump;
  assign air_pump      = status_out.air_pump;
  assign drain_pump    = status_out.drain_pump;
  assign entry_pending = status_out.entry_pending;
  assign forced        = status_out.forced;

endmodule
